### design/ir_envelope_frame_transmitter_top_assert.svh
// Assertion macros for the IR envelope frame transmitter checker.
`ifndef IR_ENVELOPE_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define IR_ENVELOPE_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define IEFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ir_eft: assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define IEFT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ir_eft: assertion failed");

`endif

### design/ir_eft_pkg.sv
// Shared types and constants of the IR envelope frame transmitter.
`timescale 1ns / 1ps

package ir_eft_pkg;

    localparam int PERIOD_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 2'd2;

    localparam logic [PERIOD_W-1:0] START_STOP_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] DATA_BIT_RST   = 16'd2000;
    localparam logic [PERIOD_W-1:0] FRAME_GAP_RST  = 16'd5000;

    // command codes carried in tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef struct packed {
        logic [PERIOD_W-1:0] start_stop_period;
        logic [PERIOD_W-1:0] data_bit_period;
        logic [PERIOD_W-1:0] frame_gap_period;
    } t_cfg;

    typedef struct packed {
        logic                send_rejected;
        logic                busy_res;
        logic [PERIOD_W-1:0] period_ticks;
        logic                envelope_on;
    } t_result;

endpackage

### design/ir_eft_cfg.sv
// Period configuration registers.
`timescale 1ns / 1ps

module ir_eft_cfg
    import ir_eft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_stop_period <= START_STOP_RST;
            r_cfg.data_bit_period   <= DATA_BIT_RST;
            r_cfg.frame_gap_period  <= FRAME_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_STOP: r_cfg.start_stop_period <= i_cfg_data;
                CFG_DATA_BIT:   r_cfg.data_bit_period   <= i_cfg_data;
                CFG_FRAME_GAP:  r_cfg.frame_gap_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/ir_eft_core.sv
// Frame sequencer: phase state, next-state decision and result word.
`timescale 1ns / 1ps

module ir_eft_core
    import ir_eft_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_frame_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam int BIT_W = $clog2(DATA_BITS + 1);
    // wide enough to hold the byte width itself
    localparam int POS_W = (BIT_W > 4) ? BIT_W : 4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_STOP  = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_stage, n_stage;
    logic [BIT_W-1:0]    r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]   r_frame, n_frame;
    logic                r_env, n_env;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                n_rejected;
    logic [POS_W-1:0]    w_pos;
    logic                w_bit;

    // bits past the byte go out as zero
    assign w_pos = POS_W'(r_bit_idx);
    assign w_bit = (w_pos < POS_W'(BYTE_W)) ? r_frame[w_pos[2:0]] : 1'b0;

    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_bit_idx  = r_bit_idx;
        n_frame    = r_frame;
        n_env      = r_env;
        n_period   = r_period;
        n_rejected = 1'b0;
        if (i_cmd == CMD_SEND) begin
            if (r_phase == PH_IDLE) begin
                n_frame   = i_frame_byte;
                n_phase   = PH_START;
                n_stage   = 2'd0;
                n_bit_idx = '0;
            end else begin
                n_rejected = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_START, PH_STOP: begin
                    if (r_phase == PH_START) begin
                        n_period = i_cfg.start_stop_period;
                    end
                    // high, low, high, low
                    n_env   = ~r_stage[0];
                    n_stage = r_stage + 2'd1;
                    if (r_stage == 2'd3) begin
                        if (r_phase == PH_START) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase  = PH_GAP;
                            n_period = i_cfg.frame_gap_period;
                        end
                    end
                end
                PH_DATA: begin
                    if (r_bit_idx < BIT_W'(DATA_BITS)) begin
                        n_period  = i_cfg.data_bit_period;
                        n_env     = w_bit;
                        n_bit_idx = r_bit_idx + BIT_W'(1);
                    end else begin
                        // settle tick
                        n_period  = i_cfg.start_stop_period;
                        n_bit_idx = '0;
                        n_phase   = PH_STOP;
                    end
                end
                PH_GAP: begin
                    n_period = i_cfg.start_stop_period;
                    n_stage  = 2'd0;
                    n_phase  = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_stage = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_stage   <= 2'd0;
            r_bit_idx <= '0;
            r_frame   <= '0;
            r_env     <= 1'b0;
            r_period  <= START_STOP_RST;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_bit_idx <= n_bit_idx;
            r_frame   <= n_frame;
            r_env     <= n_env;
            r_period  <= n_period;
        end
    end

    assign o_result.envelope_on   = n_env;
    assign o_result.period_ticks  = n_period;
    assign o_result.busy_res      = (n_phase != PH_IDLE);
    assign o_result.send_rejected = n_rejected;

endmodule

### design/ir_eft_outreg.sv
// Output word register; takes a new word whenever it is empty or being drained.
`timescale 1ns / 1ps

module ir_eft_outreg
    import ir_eft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = i_rst_n && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### design/ir_envelope_frame_transmitter_top.sv
// An accepted input word's result is registered and appears on m_axis the next cycle.
// Throughput: one word per cycle; the sequencer state updates in the accept cycle.
// The single output register is refilled in the cycle it drains, so s_axis_tready
// only drops in reset or while a result waits and m_axis_tready is low.
// Reset (synchronous, i_rst_n low): idle phase, carrier off, periods 1000/2000/5000.
`timescale 1ns / 1ps

module ir_envelope_frame_transmitter_top
    import ir_eft_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] frame_byte
    input  logic                 s_axis_tuser,  // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [0] envelope_on, [16:1] period_ticks,
                                                // [17] busy_res, [18] send_rejected, rest 0
);

    t_cfg    w_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    ir_eft_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ir_eft_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (s_axis_tuser),
        .i_frame_byte (s_axis_tdata[BYTE_W-1:0]),
        .i_cfg        (w_cfg),
        .o_result     (w_core_res)
    );

    ir_eft_outreg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (w_core_res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_res)
    );

    assign m_axis_tdata = M_TDATA_W'(w_out_res);

endmodule

### design/ir_eft_checker.sv
// Port-level checker for the IR envelope frame transmitter, bound to the top level.
`timescale 1ns / 1ps
`include "ir_envelope_frame_transmitter_top_assert.svh"

module ir_eft_checker
    import ir_eft_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // stalled result word holds
    `IEFT_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // an empty output stage never blocks the input
    `IEFT_ASSERT_IMP(a_ready_empty, !m_axis_tvalid, s_axis_tready)
    // every accepted word yields a result word next cycle
    `IEFT_ASSERT_NXT(a_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    // a rejected send only happens mid-frame
    `IEFT_ASSERT_IMP(a_rej_busy, m_axis_tvalid && m_axis_tdata[18], m_axis_tdata[17])

endmodule

bind ir_envelope_frame_transmitter_top ir_eft_checker u_ir_eft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/ir_envelope_frame_transmitter_top_tb.sv
// Self-checking testbench for the IR envelope frame transmitter: stream traffic vs a frame predictor.
`timescale 1ns / 1ps

module ir_envelope_frame_transmitter_top_tb;
    import ir_eft_pkg::*;

    localparam int FRAME_BITS  = 8;
    // start pattern, data bits, settle, stop pattern, gap
    localparam int FRAME_TICKS = FRAME_BITS + 10;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_WORDS = 355;
    localparam int RES_W       = $bits(t_result);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [2:0] {FR_IDLE, FR_START, FR_BITS, FR_STOP, FR_GAP} t_frame_phase;

    typedef struct {
        logic              cmd;
        logic [BYTE_W-1:0] fbyte;
        int unsigned       pause;
    } t_tx_word;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [PERIOD_W-1:0]  i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [7:0] frame_byte
    logic                 s_axis_tuser  = 1'b0; // [0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [0] envelope_on, [16:1] period_ticks,
                                               // [17] busy_res, [18] send_rejected

    // predictor state
    t_cfg                cfg_model  = '{START_STOP_RST, DATA_BIT_RST, FRAME_GAP_RST};
    t_frame_phase        fr_phase   = FR_IDLE;
    logic [1:0]          fr_stage   = '0;
    logic [5:0]          fr_bit     = '0;
    logic [BYTE_W-1:0]   fr_data    = '0;
    logic                fr_level   = 1'b0;
    logic [PERIOD_W-1:0] fr_period  = START_STOP_RST;

    t_tx_word    pending_q[$];
    t_result     envelope_q[$];
    t_tx_word    tx_next;
    int unsigned tx_gap      = 0;
    int unsigned rx_stall    = 0;
    int unsigned rx_calm     = 0;
    int unsigned idle_cycles = 0;
    logic        s_fire      = 1'b0;
    int          n_queued    = 0;
    int          n_words     = 0;
    int          n_results   = 0;
    int          n_frames    = 0;
    int          n_rejects   = 0;
    int          n_err       = 0;

    ir_envelope_frame_transmitter_top #(
        .DATA_BITS(FRAME_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // high/low pattern shared by start and stop
    function automatic void pattern_advance();
        case (fr_stage)
            2'd0: begin fr_level = 1'b1; fr_stage = 2'd1; end
            2'd1: begin fr_level = 1'b0; fr_stage = 2'd2; end
            2'd2: begin fr_level = 1'b1; fr_stage = 2'd3; end
            default: begin
                fr_level = 1'b0;
                fr_stage = 2'd0;
                if (fr_phase == FR_START) begin
                    fr_phase = FR_BITS;
                end else begin
                    fr_period = cfg_model.frame_gap_period;
                    fr_phase  = FR_GAP;
                end
            end
        endcase
    endfunction

    function automatic t_result envelope_step(logic cmd, logic [BYTE_W-1:0] fbyte);
        t_result r;
        r.send_rejected = 1'b0;
        if (cmd == CMD_SEND) begin
            if (fr_phase == FR_IDLE) begin
                fr_data  = fbyte;
                fr_phase = FR_START;
                fr_stage = 2'd0;
                fr_bit   = '0;
                n_frames++;
            end else begin
                r.send_rejected = 1'b1;
                n_rejects++;
            end
        end else begin
            case (fr_phase)
                FR_START: begin
                    fr_period = cfg_model.start_stop_period;
                    pattern_advance();
                end
                FR_BITS: begin
                    fr_period = cfg_model.data_bit_period;
                    if (fr_bit < FRAME_BITS) begin
                        fr_level = (fr_bit < 8) ? fr_data[fr_bit[2:0]] : 1'b0;
                        fr_bit   = fr_bit + 6'd1;
                    end else begin
                        // settle tick
                        fr_bit    = '0;
                        fr_phase  = FR_STOP;
                        fr_period = cfg_model.start_stop_period;
                    end
                end
                FR_STOP: pattern_advance();
                FR_GAP: begin
                    fr_period = cfg_model.start_stop_period;
                    fr_stage  = 2'd0;
                    fr_phase  = FR_IDLE;
                end
                default: ;
            endcase
        end
        r.envelope_on  = fr_level;
        r.period_ticks = fr_period;
        r.busy_res     = (fr_phase != FR_IDLE);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    task automatic note_error(string msg);
        if (n_err < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        n_err++;
    endtask

    task automatic queue_word(logic cmd, logic [BYTE_W-1:0] fbyte, logic calm);
        t_tx_word w;
        w.cmd   = cmd;
        w.fbyte = fbyte;
        w.pause = (calm || $urandom_range(99) >= 25) ? 0 : pick_gap();
        pending_q.push_back(w);
        n_queued++;
    endtask

    // send command followed by ticks; a short tick count leaves a broken frame behind
    task automatic queue_frame(logic calm);
        logic [BYTE_W-1:0] b;
        int                sel;
        int                ticks;
        sel   = $urandom_range(9);
        b     = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
        ticks = ($urandom_range(9) == 0) ? $urandom_range(FRAME_TICKS) : FRAME_TICKS;
        queue_word(CMD_SEND, b, calm);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(9) == 0)
                queue_word(CMD_SEND, 8'($urandom), calm);
            queue_word(CMD_TICK, 8'($urandom), calm);
        end
        repeat ($urandom_range(2)) queue_word(CMD_TICK, 8'($urandom), calm);
    endtask

    // caller is at a falling edge; leaves we high, caller lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_START_STOP: cfg_model.start_stop_period = val;
            CFG_DATA_BIT:   cfg_model.data_bit_period   = val;
            CFG_FRAME_GAP:  cfg_model.frame_gap_period  = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || envelope_q.size() != 0);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_fire)) begin
            if (tx_gap != 0) begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                tx_next        = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= tx_next.cmd;
                s_axis_tdata  <= tx_next.fbyte;
                tx_gap        <= tx_next.pause;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with calm stretches of steady ready
    always @(negedge i_clk) begin
        int roll;
        roll = $urandom_range(99);
        if (rx_calm != 0) begin
            rx_calm       <= rx_calm - 1;
            m_axis_tready <= 1'b1;
        end else if (rx_stall != 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (roll < 3) begin
            rx_calm       <= $urandom_range(200, 50);
            m_axis_tready <= 1'b1;
        end else if (roll < 22) begin
            rx_stall      <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result check first, then prediction of the word accepted at this edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RES_W-1:0]);
            n_results++;
            if (envelope_q.size() == 0) begin
                note_error($sformatf("unexpected result word %h", m_axis_tdata));
            end else begin
                want = envelope_q.pop_front();
                if (got !== want || m_axis_tdata[M_TDATA_W-1:RES_W] !== '0)
                    note_error($sformatf({"result %0d: exp env=%0b per=%0d busy=%0b rej=%0b,",
                        " got env=%0b per=%0d busy=%0b rej=%0b pad=%0h"}, n_results,
                        want.envelope_on, want.period_ticks, want.busy_res, want.send_rejected,
                        got.envelope_on, got.period_ticks, got.busy_res, got.send_rejected,
                        m_axis_tdata[M_TDATA_W-1:RES_W]));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            envelope_q.push_back(envelope_step(s_axis_tuser, s_axis_tdata));
            n_words++;
        end
        s_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int target;
        logic calm;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, a frame of all ones, send while busy, idle tick, frame of all zeros
        queue_word(CMD_TICK, 8'h5A, 1'b1);
        queue_word(CMD_SEND, 8'hFF, 1'b1);
        queue_word(CMD_SEND, 8'h00, 1'b1);
        for (int k = 0; k < FRAME_TICKS; k++)
            queue_word(CMD_TICK, (k % 2) ? 8'hFF : 8'h00, 1'b1);
        queue_word(CMD_TICK, 8'hFF, 1'b1);
        queue_word(CMD_SEND, 8'h00, 1'b1);
        for (int k = 0; k < FRAME_TICKS; k++)
            queue_word(CMD_TICK, 8'h00, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_START_STOP, 16'd1);
                    write_reg(CFG_DATA_BIT, 16'hFFFF);
                    write_reg(CFG_FRAME_GAP, 16'd1);
                    write_reg(CFG_SPARE, 16'hA5A5);
                end
                2: begin
                    write_reg(CFG_START_STOP, 16'hFFFF);
                    write_reg(CFG_DATA_BIT, 16'd1);
                    write_reg(CFG_FRAME_GAP, 16'hFFFF);
                end
                3: begin
                    // zero periods pass straight through
                    write_reg(CFG_START_STOP, 16'd0);
                    write_reg(CFG_DATA_BIT, 16'd0);
                    write_reg(CFG_FRAME_GAP, 16'd0);
                end
                4: begin
                    write_reg(CFG_START_STOP, 16'($urandom_range(65535, 1)));
                    write_reg(CFG_DATA_BIT, 16'($urandom_range(65535, 1)));
                    write_reg(CFG_FRAME_GAP, 16'($urandom_range(65535, 1)));
                    write_reg(CFG_SPARE, 16'($urandom));
                end
                default: ;
            endcase
            i_cfg_we <= 1'b0;

            target = n_queued + PHASE_WORDS;
            while (n_queued < target) begin
                calm = ($urandom_range(3) == 0);
                if ($urandom_range(99) < 12) begin
                    repeat ($urandom_range(8, 1))
                        queue_word(1'($urandom_range(1)), 8'($urandom), calm);
                end else begin
                    queue_frame(calm);
                end
            end
            // flush any frame still running before the next register change
            repeat (FRAME_TICKS + 2) queue_word(CMD_TICK, 8'($urandom), 1'b0);
            wait_drained();
        end

        repeat (5) @(posedge i_clk);
        $display("covered %0d words, %0d results, %0d frames sent, %0d sends refused",
                 n_words, n_results, n_frames, n_rejects);
        $display("periods: reset, min/max, zero and random settings; %0d mismatches", n_err);
        if (n_err == 0 && envelope_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/ir_eft_pkg.sv
design/ir_eft_cfg.sv
design/ir_eft_core.sv
design/ir_eft_outreg.sv
design/ir_envelope_frame_transmitter_top.sv
design/ir_eft_checker.sv
sim/ir_envelope_frame_transmitter_top_tb.sv
